FILE: rtl/lasc_pkg.sv
`default_nettype none
package lasc_pkg;

  localparam int MAX_QUERY  = 256;
  localparam int SCORE_BITS = 16;
  localparam int COL_BITS   = 16;
  localparam int SYM_BITS   = 8;

  localparam int QLEN_BITS  = $clog2(MAX_QUERY + 1);
  localparam int IDX_BITS   = $clog2(MAX_QUERY);
  localparam int BND_BITS   = COL_BITS + 11;
  localparam int VAL_BITS   = SCORE_BITS + 2;
  localparam int CALC_BITS  = (BND_BITS > VAL_BITS) ? BND_BITS : VAL_BITS;

  localparam logic [SCORE_BITS-1:0] SCORE_MAX = {SCORE_BITS{1'b1}};
  localparam logic [COL_BITS-1:0]   COL_MAX   = {COL_BITS{1'b1}};

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_TARGET = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  localparam logic [1:0] REG_MATCH    = 2'd0;
  localparam logic [1:0] REG_MISMATCH = 2'd1;
  localparam logic [1:0] REG_GAP      = 2'd2;

  typedef struct packed {
    logic [6:0]        match;
    logic signed [7:0] mismatch;
    logic signed [7:0] gap;
  } lasc_cfg_t;

  typedef struct packed {
    logic                        valid;
    logic [QLEN_BITS-1:0]        rows_left;
    logic [SYM_BITS-1:0]         sym;
    logic                        first;
    logic                        col0;
    logic signed [CALC_BITS-1:0] bnd;
    logic [SCORE_BITS-1:0]       above;
    logic [SCORE_BITS-1:0]       diag;
  } lasc_tok_t;

endpackage
`default_nettype wire

FILE: rtl/lasc_if.sv
`default_nettype none
interface lasc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] symbol;
  modport source (output valid, action, symbol, input ready);
  modport sink   (input valid, action, symbol, output ready);
endinterface

interface lasc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [15:0] column_index;
  logic [15:0] last_row_score;
  logic        new_best;
  logic [15:0] best_score;
  modport source (output valid, status, column_index, last_row_score, new_best, best_score,
                  input ready);
  modport sink   (input valid, status, column_index, last_row_score, new_best, best_score,
                  output ready);
endinterface
`default_nettype wire

FILE: rtl/lasc_cell.sv
`default_nettype none
module lasc_cell (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire lasc_pkg::lasc_cfg_t                cfg,
  input  wire logic [lasc_pkg::IDX_BITS-1:0]      cell_idx,
  input  wire logic                               load_en,
  input  wire logic [lasc_pkg::IDX_BITS-1:0]      load_idx,
  input  wire logic [lasc_pkg::SYM_BITS-1:0]      load_sym,
  input  wire lasc_pkg::lasc_tok_t                tin,
  output lasc_pkg::lasc_tok_t                     tout
);
  localparam int CW = lasc_pkg::CALC_BITS;
  localparam int SB = lasc_pkg::SCORE_BITS;

  logic [lasc_pkg::SYM_BITS-1:0] qsym;
  logic [SB-1:0]                 prev;
  logic                          active;
  logic signed [CW-1:0]          m, gap, b_v, d_v, u_v, l_v, best_v, v_raw;
  logic [SB-1:0]                 v;

  always_comb begin
    active = tin.valid && (tin.rows_left != '0);
    gap    = CW'(cfg.gap);
    m      = (qsym == tin.sym) ? $signed({{(CW-7){1'b0}}, cfg.match}) : CW'(cfg.mismatch);
    b_v    = tin.bnd + m;
    d_v    = $signed({{(CW-SB){1'b0}}, tin.diag}) + m;
    u_v    = $signed({{(CW-SB){1'b0}}, tin.above}) + gap;
    l_v    = $signed({{(CW-SB){1'b0}}, prev}) + gap;
    best_v = d_v;
    if (u_v > best_v) best_v = u_v;
    if (l_v > best_v) best_v = l_v;
    v_raw  = (tin.first || tin.col0) ? b_v : best_v;
    if (v_raw < 0) begin
      v = '0;
    end else if (v_raw > $signed({{(CW-SB){1'b0}}, lasc_pkg::SCORE_MAX})) begin
      v = lasc_pkg::SCORE_MAX;
    end else begin
      v = v_raw[SB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_en && (load_idx == cell_idx)) qsym <= load_sym;
    if (active) prev <= v;
    tout.rows_left <= active ? tin.rows_left - 1'b1 : tin.rows_left;
    tout.sym       <= tin.sym;
    tout.first     <= 1'b0;
    tout.col0      <= tin.col0;
    tout.bnd       <= tin.bnd + gap;
    tout.above     <= active ? v : tin.above;
    tout.diag      <= active ? prev : tin.diag;
    if (rst) begin
      tout.valid <= 1'b0;
    end else begin
      tout.valid <= tin.valid;
    end
  end
endmodule
`default_nettype wire

FILE: rtl/local_alignment_score_column.sv
`default_nettype none
// Channel | Dir | Payload                                                  | Accepted when
// in_ch   | in  | action[1:0], symbol[7:0]                                 | valid & ready
// out_ch  | out | status, column_index, last_row_score, new_best, best_score | valid & ready
// cfg     | in  | cfg_index[1:0], cfg_wdata[7:0]                           | cfg_we
// Clear, append, unused and empty-query target requests pass through DONE to the output register.
// A target request on a non-empty query goes through PREP and RUN: the score token walks the
// whole cell chain, one cell per cycle, whatever the query length.
// One request is in work at a time; a new one is taken while a result waits.
// rst is synchronous; no clearing pass, query and column cells fill on use.
module local_alignment_score_column (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [7:0] cfg_wdata,
  lasc_in_if.sink         in_ch,
  lasc_out_if.source      out_ch
);
  localparam int MQ = lasc_pkg::MAX_QUERY;
  localparam int CW = lasc_pkg::CALC_BITS;
  localparam int SB = lasc_pkg::SCORE_BITS;
  localparam int QB = lasc_pkg::QLEN_BITS;

  typedef enum logic [1:0] {IDLE, PREP, RUN, DONE} state_t;

  state_t                           state;
  lasc_pkg::lasc_cfg_t              cfg;
  lasc_pkg::lasc_tok_t              tok [0:MQ];
  logic [QB-1:0]                    qlen;
  logic [lasc_pkg::COL_BITS-1:0]    col_cnt;
  logic [SB-1:0]                    best;
  logic                             best_valid;
  logic [lasc_pkg::SYM_BITS-1:0]    tsym;
  logic signed [CW-1:0]             prod;
  logic [1:0]                       res_status;
  logic [15:0]                      res_col;
  logic [15:0]                      res_last;
  logic                             res_flag;
  logic                             accept, full, load_en, flag;
  logic [SB-1:0]                    last;

  assign in_ch.ready = (state == IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign full        = (qlen >= QB'(MQ));
  assign load_en     = accept && (in_ch.action == lasc_pkg::ACT_APPEND) && !full;
  assign last        = tok[MQ].above;
  assign flag        = !best_valid || (last > best);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match    <= 7'd10;
      cfg.mismatch <= -8'sd10;
      cfg.gap      <= -8'sd10;
    end else if (cfg_we) begin
      case (cfg_index)
        lasc_pkg::REG_MATCH:    cfg.match    <= cfg_wdata[6:0];
        lasc_pkg::REG_MISMATCH: cfg.mismatch <= $signed(cfg_wdata);
        lasc_pkg::REG_GAP:      cfg.gap      <= $signed(cfg_wdata);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    tok[0].rows_left <= qlen;
    tok[0].sym       <= tsym;
    tok[0].first     <= 1'b1;
    tok[0].col0      <= (col_cnt == '0);
    tok[0].bnd       <= prod;
    tok[0].above     <= '0;
    tok[0].diag      <= '0;
    if (rst) begin
      state          <= IDLE;
      qlen           <= '0;
      col_cnt        <= '0;
      best           <= '0;
      best_valid     <= 1'b0;
      tok[0].valid   <= 1'b0;
      out_ch.valid   <= 1'b0;
    end else begin
      tok[0].valid <= (state == PREP);
      if ((state != DONE) && out_ch.valid && out_ch.ready) out_ch.valid <= 1'b0;
      case (state)
        IDLE: begin
          if (accept) begin
            res_col    <= '0;
            res_last   <= '0;
            res_flag   <= 1'b0;
            case (in_ch.action)
              lasc_pkg::ACT_CLEAR: begin
                res_status <= lasc_pkg::ST_OK;
                state      <= DONE;
                qlen       <= '0;
                col_cnt    <= '0;
                best       <= '0;
                best_valid <= 1'b0;
              end
              lasc_pkg::ACT_APPEND: begin
                state <= DONE;
                if (full) begin
                  res_status <= lasc_pkg::ST_FULL;
                end else begin
                  res_status <= lasc_pkg::ST_OK;
                  qlen       <= qlen + 1'b1;
                  col_cnt    <= '0;
                  best       <= '0;
                  best_valid <= 1'b0;
                end
              end
              lasc_pkg::ACT_TARGET: begin
                if (qlen == '0) begin
                  res_status <= lasc_pkg::ST_EMPTY;
                  state      <= DONE;
                end else begin
                  res_status <= lasc_pkg::ST_OK;
                  tsym  <= in_ch.symbol;
                  prod  <= $signed({{(CW-lasc_pkg::COL_BITS){1'b0}}, col_cnt})
                           * CW'(cfg.gap);
                  state <= PREP;
                end
              end
              default: begin
                res_status <= lasc_pkg::ST_OK;
                state      <= DONE;
              end
            endcase
          end
        end
        PREP: begin
          state <= RUN;
        end
        RUN: begin
          if (tok[MQ].valid) begin
            res_col  <= 16'(col_cnt);
            res_last <= 16'(last);
            res_flag <= flag;
            if (flag) begin
              best       <= last;
              best_valid <= 1'b1;
            end
            if (col_cnt != lasc_pkg::COL_MAX) col_cnt <= col_cnt + 1'b1;
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid          <= 1'b1;
            out_ch.status         <= res_status;
            out_ch.column_index   <= res_col;
            out_ch.last_row_score <= res_last;
            out_ch.new_best       <= res_flag;
            out_ch.best_score     <= 16'(best);
            state                 <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  for (genvar g = 0; g < MQ; g++) begin : g_cell
    lasc_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .cfg      (cfg),
      .cell_idx (lasc_pkg::IDX_BITS'(g)),
      .load_en  (load_en),
      .load_idx (qlen[lasc_pkg::IDX_BITS-1:0]),
      .load_sym (in_ch.symbol),
      .tin      (tok[g]),
      .tout     (tok[g+1])
    );
  end

  a_tok_in_run: assert property (@(posedge clk) disable iff (rst)
    tok[MQ].valid |-> state == RUN) else $error("token left chain outside run");
  a_qlen_max: assert property (@(posedge clk) disable iff (rst)
    qlen <= QB'(MQ)) else $error("query length overflow");
  a_best_match: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.new_best |-> out_ch.best_score == out_ch.last_row_score)
    else $error("new best differs from best score");
  a_launch: assert property (@(posedge clk) disable iff (rst)
    state == PREP |=> tok[0].valid) else $error("token not launched");
endmodule
`default_nettype wire
